@@ rtl/tcg_pkg.sv @@
package tcg_pkg;

	localparam int FONT_AW = 12;
	localparam int ROW_W = 4;
	localparam int ADDR_W = 11;
	localparam int APB_AW = 5;

	localparam logic [15:0] BLINK_PERIOD_RESET = 16'd16;
	localparam logic [ADDR_W-1:0] CURSOR_ADDR_RESET = 11'h7FF;
	localparam logic [4:0] CURSOR_START_RESET = 5'd8;
	localparam logic [4:0] CURSOR_END_RESET = 5'd9;

	typedef enum logic {
		OP_RENDER = 1'b0,
		OP_LOAD   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_BLINK_ENABLE = 3'd0,
		REG_BLINK_PERIOD = 3'd1,
		REG_CURSOR_START = 3'd2,
		REG_CURSOR_END   = 3'd3,
		REG_INVERSE_MODE = 3'd4,
		REG_CURSOR_ADDR  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic              blink_enable;
		logic [15:0]       blink_period;
		logic [4:0]        cursor_start_row;
		logic [4:0]        cursor_end_row;
		logic              inverse_mode;
		logic [ADDR_W-1:0] cursor_address;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic [FONT_AW-1:0] base;
		logic [ROW_W-1:0]  grow;
		logic [7:0]        bits;
		logic              flip;
		logic              cur;
	} item_t;

endpackage

@@ rtl/tcg_font_ram.sv @@
module tcg_font_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [tcg_pkg::FONT_AW-1:0]  waddr,
	input  logic [7:0]                   wdata,
	input  logic                         re,
	input  logic [tcg_pkg::FONT_AW-1:0]  raddr,
	output logic [7:0]                   rdata
);
	import tcg_pkg::*;

	logic [7:0] mem [2**FONT_AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/tcg_cursor.sv @@
module tcg_cursor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [tcg_pkg::ADDR_W-1:0]  cell_address,
	input  tcg_pkg::cfg_t               cfg,
	output logic                        invert
);
	import tcg_pkg::*;

	logic              lit_q;
	logic [15:0]       count_q;
	logic [ADDR_W-1:0] prev_q;
	logic              moved;
	logic              on_cursor;
	logic              lit0;
	logic              lit1;
	logic [15:0]       count0;
	logic [15:0]       count1;

	always_comb begin
		moved = cfg.cursor_address != prev_q;
		lit0 = moved ? 1'b0 : lit_q;
		count0 = moved ? 16'd0 : count_q;
		on_cursor = cell_address == cfg.cursor_address;
		lit1 = lit0;
		count1 = count0;
		if (on_cursor) begin
			if (cfg.blink_enable) begin
				if (count0 == 16'd0) begin
					count1 = cfg.blink_period;
					lit1 = ~lit0;
				end else begin
					count1 = count0 - 16'd1;
				end
			end else begin
				lit1 = 1'b1;
			end
		end
		invert = on_cursor && lit1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q <= 1'b0;
			count_q <= BLINK_PERIOD_RESET;
			prev_q <= '0;
		end else if (step) begin
			lit_q <= lit1;
			count_q <= count1;
			prev_q <= cfg.cursor_address;
		end
	end

`ifndef NO_ASSERTIONS
	a_prev_follows: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> prev_q == $past(cfg.cursor_address))
		else $error("cursor address not captured on render");
	a_move_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && moved && !on_cursor |=> !lit_q && count_q == 16'd0)
		else $error("cursor move did not restart the blink");
	a_steady_lit: assert property (@(posedge clk) disable iff (!arst_n)
		step && on_cursor && !cfg.blink_enable |-> invert)
		else $error("steady cursor not lit");
`endif

endmodule

@@ rtl/tcg_render.sv @@
module tcg_render #(
	parameter int GLYPH_ROWS = 10,
	parameter int GLYPH_STRIDE = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  tcg_pkg::item_t             item,
	input  tcg_pkg::cfg_t              cfg,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 pixel_row,
	output logic [tcg_pkg::ROW_W-1:0]  row_number,
	output logic                       last_row
);
	import tcg_pkg::*;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);
	localparam logic [ROW_W:0] STRIDE_LIM = (ROW_W + 1)'(GLYPH_STRIDE);

	item_t            itm_q;
	logic             itm_valid_q;
	logic [ROW_W-1:0] row_q;
	logic             v_s1;
	logic [ROW_W-1:0] row_s1;
	logic             last_s1;
	logic             flip_s1;
	logic             inv_s1;
	logic             out_valid_q;
	logic [7:0]       pixel_q;
	logic [ROW_W-1:0] row_num_q;
	logic             last_q;
	logic             out_adv;
	logic             s1_free;
	logic             issue_rd;
	logic             issue_wr;
	logic             itm_done;
	logic             row_inv;
	logic             ram_we;
	logic [7:0]       rdata;

	always_comb begin
		out_adv = !out_valid_q || out_ready;
		s1_free = !v_s1 || out_adv;
		issue_rd = itm_valid_q && itm_q.op == OP_RENDER && s1_free;
		issue_wr = itm_valid_q && itm_q.op == OP_LOAD;
		itm_done = issue_wr || (issue_rd && row_q == LAST_ROW);
		in_ready = !itm_valid_q || itm_done;
		ram_we = issue_wr && ({1'b0, itm_q.grow} < STRIDE_LIM);
		row_inv = itm_q.cur && ({1'b0, row_q} >= cfg.cursor_start_row)
			&& ({1'b0, row_q} <= cfg.cursor_end_row);
	end

	tcg_font_ram u_font (
		.clk   (clk),
		.we    (ram_we),
		.waddr (itm_q.base + FONT_AW'(itm_q.grow)),
		.wdata (itm_q.bits),
		.re    (issue_rd),
		.raddr (itm_q.base + FONT_AW'(row_q)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itm_valid_q <= 1'b0;
			row_q <= '0;
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				itm_valid_q <= 1'b1;
			end else if (itm_done) begin
				itm_valid_q <= 1'b0;
			end
			if (issue_rd) begin
				row_q <= (row_q == LAST_ROW) ? '0 : row_q + 1'b1;
			end
			if (s1_free) begin
				v_s1 <= issue_rd;
			end
			if (out_adv) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			itm_q <= item;
		end
		if (s1_free) begin
			row_s1 <= row_q;
			last_s1 <= row_q == LAST_ROW;
			flip_s1 <= itm_q.flip;
			inv_s1 <= row_inv;
		end
		if (out_adv) begin
			pixel_q <= rdata ^ {8{flip_s1}} ^ {8{inv_s1}};
			row_num_q <= row_s1;
			last_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_row = pixel_q;
	assign row_number = row_num_q;
	assign last_row = last_q;

`ifndef NO_ASSERTIONS
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_row |=>
		!out_valid || row_number == ROW_W'($past(row_number) + 1'b1))
		else $error("glyph rows out of order");
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_row == (row_number == LAST_ROW))
		else $error("last row mark wrong");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !out_adv |=> v_s1 && $stable(row_s1) && $stable(rdata))
		else $error("read stage lost data under stall");
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(issue_rd && ram_we))
		else $error("font memory read and write in one cycle");
`endif

endmodule

@@ rtl/text_char_generator_cursor.sv @@
// Channel   Handshake              Payload
// input     in_valid / in_ready    op, cell_address, char_code, glyph_row, glyph_bits
// output    out_valid / out_ready  pixel_row, row_number, last_row
// config    APB psel / penable     paddr, pwrite, pwdata, prdata, pready
// A render transfer makes one font memory read per row, GLYPH_ROWS reads in all; a font load
// makes one write. The font memory serves one access at a time, so items go through in turn.
// The first row goes through the item register, the read stage and the output register.
// Reset loads the configuration registers and the cursor blink state with their reset values;
// the font memory is not cleared. A stalled output holds one row while the next row waits in the read stage.
module text_char_generator_cursor #(
	parameter int GLYPH_ROWS = 10,
	parameter int GLYPH_STRIDE = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic [10:0]                  cell_address,
	input  logic [7:0]                   char_code,
	input  logic [3:0]                   glyph_row,
	input  logic [7:0]                   glyph_bits,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   pixel_row,
	output logic [3:0]                   row_number,
	output logic                         last_row,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tcg_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import tcg_pkg::*;

	cfg_t        cfg_q;
	item_t       item;
	reg_idx_t    reg_idx;
	logic        cur_invert;
	logic        upper;
	logic [7:0]  glyph;
	logic        accept_render;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_enable <= 1'b1;
			cfg_q.blink_period <= BLINK_PERIOD_RESET;
			cfg_q.cursor_start_row <= CURSOR_START_RESET;
			cfg_q.cursor_end_row <= CURSOR_END_RESET;
			cfg_q.inverse_mode <= 1'b0;
			cfg_q.cursor_address <= CURSOR_ADDR_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_BLINK_ENABLE: cfg_q.blink_enable <= pwdata[0];
				REG_BLINK_PERIOD: cfg_q.blink_period <= pwdata[15:0];
				REG_CURSOR_START: cfg_q.cursor_start_row <= pwdata[4:0];
				REG_CURSOR_END:   cfg_q.cursor_end_row <= pwdata[4:0];
				REG_INVERSE_MODE: cfg_q.inverse_mode <= pwdata[0];
				REG_CURSOR_ADDR:  cfg_q.cursor_address <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BLINK_ENABLE: prdata = 32'(cfg_q.blink_enable);
			REG_BLINK_PERIOD: prdata = 32'(cfg_q.blink_period);
			REG_CURSOR_START: prdata = 32'(cfg_q.cursor_start_row);
			REG_CURSOR_END:   prdata = 32'(cfg_q.cursor_end_row);
			REG_INVERSE_MODE: prdata = 32'(cfg_q.inverse_mode);
			REG_CURSOR_ADDR:  prdata = 32'(cfg_q.cursor_address);
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		accept_render = in_valid && in_ready && op_t'(op) == OP_RENDER;
		upper = op_t'(op) == OP_RENDER && cfg_q.inverse_mode && char_code[7];
		glyph = upper ? {1'b0, char_code[6:0]} : char_code;
		item.op = op_t'(op);
		item.base = FONT_AW'(glyph * GLYPH_STRIDE);
		item.grow = glyph_row;
		item.bits = glyph_bits;
		item.flip = upper;
		item.cur = cur_invert;
	end

	tcg_cursor u_cursor (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (accept_render),
		.cell_address (cell_address),
		.cfg          (cfg_q),
		.invert       (cur_invert)
	);

	tcg_render #(
		.GLYPH_ROWS   (GLYPH_ROWS),
		.GLYPH_STRIDE (GLYPH_STRIDE)
	) u_render (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.item       (item),
		.cfg        (cfg_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_row  (pixel_row),
		.row_number (row_number),
		.last_row   (last_row)
	);

endmodule

@@ tb/text_char_generator_cursor_tb.sv @@
module text_char_generator_cursor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcg_pkg::*;

	localparam int GLYPH_ROWS = 10;
	localparam int GLYPH_STRIDE = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [7:0] FIRST_GLYPH [GLYPH_ROWS] = '{
		8'h00, 8'hFF, 8'h81, 8'h7E, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h0F, 8'hF0
	};

	typedef struct {
		op_t         op;
		logic [10:0] cell_addr;
		logic [7:0]  code;
		logic [3:0]  grow;
		logic [7:0]  bits;
	} cell_item_t;

	typedef struct {
		logic [7:0] pixels;
		logic [3:0] row;
		logic       last;
	} glyph_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = 1'b0;
	logic [10:0] cell_address = '0;
	logic [7:0] char_code = '0;
	logic [3:0] glyph_row = '0;
	logic [7:0] glyph_bits = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] pixel_row;
	logic [3:0] row_number;
	logic last_row;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	cell_item_t cells_to_send[$];
	cell_item_t cur_item;
	glyph_row_t glyph_rows_due[$];

	cfg_t cfg;
	logic [7:0] font_img [4096];
	bit loaded [4096];
	logic lit;
	logic [15:0] countdown;
	logic [ADDR_W-1:0] prev_cursor;

	bit sender_idles = 1'b0;
	bit receiver_stalls = 1'b0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	int unsigned queued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned errors = 0;
	int unsigned rows_seen = 0;
	int unsigned cells_drawn = 0;
	int unsigned font_writes = 0;
	int unsigned cursor_visits = 0;
	int unsigned settings_used = 0;
	int unsigned cycles = 0;

	text_char_generator_cursor #(
		.GLYPH_ROWS(GLYPH_ROWS),
		.GLYPH_STRIDE(GLYPH_STRIDE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.cell_address(cell_address),
		.char_code(char_code),
		.glyph_row(glyph_row),
		.glyph_bits(glyph_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_row(pixel_row),
		.row_number(row_number),
		.last_row(last_row),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void predict_cell(cell_item_t it);
		logic [7:0] glyph;
		logic [7:0] flip;
		logic [7:0] line;
		logic on_cur;
		glyph_row_t r;
		if (it.op == OP_LOAD) begin
			if (it.grow < GLYPH_STRIDE)
				font_img[12'(it.code * GLYPH_STRIDE + it.grow)] = it.bits;
			font_writes++;
			return;
		end
		cells_drawn++;
		if (cfg.cursor_address != prev_cursor) begin
			lit = 1'b0;
			countdown = '0;
			prev_cursor = cfg.cursor_address;
		end
		on_cur = (it.cell_addr == cfg.cursor_address);
		if (on_cur) begin
			cursor_visits++;
			if (cfg.blink_enable) begin
				if (countdown == 0) begin
					countdown = cfg.blink_period;
					lit = ~lit;
				end else begin
					countdown = countdown - 16'd1;
				end
			end else begin
				lit = 1'b1;
			end
		end
		if (cfg.inverse_mode && it.code[7]) begin
			glyph = {1'b0, it.code[6:0]};
			flip = 8'hFF;
		end else begin
			glyph = it.code;
			flip = 8'h00;
		end
		for (int y = 0; y < GLYPH_ROWS; y++) begin
			line = font_img[12'(glyph * GLYPH_STRIDE + y)] ^ flip;
			if (on_cur && lit && y >= cfg.cursor_start_row && y <= cfg.cursor_end_row)
				line = ~line;
			r.pixels = line;
			r.row = 4'(y);
			r.last = (y == GLYPH_ROWS - 1);
			glyph_rows_due.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : sender
		cell_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_cell(cur_item);
				accepted_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (tx_wait != 0) begin
					in_valid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (cells_to_send.size() != 0) begin
					it = cells_to_send.pop_front();
					cur_item <= it;
					op <= it.op;
					cell_address <= it.cell_addr;
					char_code <= it.code;
					glyph_row <= it.grow;
					glyph_bits <= it.bits;
					in_valid <= 1'b1;
					tx_wait <= sender_idles ? $urandom_range(0, 5) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : receiver
		glyph_row_t want;
		int unsigned pause;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (glyph_rows_due.size() == 0) begin
					$error("unexpected glyph row: pixel_row %h row_number %0d", pixel_row,
						row_number);
					errors++;
				end else begin
					want = glyph_rows_due.pop_front();
					if (pixel_row !== want.pixels) begin
						$error("pixel_row: expected %h, got %h", want.pixels, pixel_row);
						errors++;
					end
					if (row_number !== want.row) begin
						$error("row_number: expected %0d, got %0d", want.row, row_number);
						errors++;
					end
					if (last_row !== want.last) begin
						$error("last_row: expected %0d, got %0d", want.last, last_row);
						errors++;
					end
					rows_seen++;
				end
				pause = receiver_stalls ? $urandom_range(0, 5) : 0;
				out_ready <= (pause == 0);
				rx_wait <= pause;
			end else if (!out_ready) begin
				if (rx_wait == 0)
					out_ready <= 1'b1;
				else
					rx_wait <= rx_wait - 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic set_reg(reg_idx_t idx, logic [15:0] val);
		logic [31:0] want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BLINK_ENABLE: begin
				cfg.blink_enable = val[0];
				want = 32'(cfg.blink_enable);
			end
			REG_BLINK_PERIOD: begin
				cfg.blink_period = val;
				want = 32'(cfg.blink_period);
			end
			REG_CURSOR_START: begin
				cfg.cursor_start_row = val[4:0];
				want = 32'(cfg.cursor_start_row);
			end
			REG_CURSOR_END: begin
				cfg.cursor_end_row = val[4:0];
				want = 32'(cfg.cursor_end_row);
			end
			REG_INVERSE_MODE: begin
				cfg.inverse_mode = val[0];
				want = 32'(cfg.inverse_mode);
			end
			default: begin
				cfg.cursor_address = val[ADDR_W-1:0];
				want = 32'(cfg.cursor_address);
			end
		endcase
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("%s: expected %h, got %h", idx.name(), want, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(cfg_t c);
		set_reg(REG_BLINK_ENABLE, 16'(c.blink_enable));
		set_reg(REG_BLINK_PERIOD, c.blink_period);
		set_reg(REG_CURSOR_START, 16'(c.cursor_start_row));
		set_reg(REG_CURSOR_END, 16'(c.cursor_end_row));
		set_reg(REG_INVERSE_MODE, 16'(c.inverse_mode));
		set_reg(REG_CURSOR_ADDR, 16'(c.cursor_address));
		settings_used++;
	endtask

	function automatic void send_load(logic [7:0] code, logic [3:0] grow, logic [7:0] bits);
		cell_item_t it;
		it.op = OP_LOAD;
		it.cell_addr = 11'($urandom_range(0, 2047));
		it.code = code;
		it.grow = grow;
		it.bits = bits;
		if (grow < GLYPH_STRIDE)
			loaded[12'(code * GLYPH_STRIDE + grow)] = 1'b1;
		cells_to_send.push_back(it);
		queued_cnt++;
	endfunction

	function automatic void send_render(logic [10:0] cell_addr, logic [7:0] code);
		cell_item_t it;
		it.op = OP_RENDER;
		it.cell_addr = cell_addr;
		it.code = code;
		it.grow = 4'($urandom_range(0, 15));
		it.bits = 8'($urandom_range(0, 255));
		cells_to_send.push_back(it);
		queued_cnt++;
	endfunction

	function automatic bit glyph_ready(logic [7:0] code);
		logic [7:0] g;
		g = (cfg.inverse_mode && code[7]) ? {1'b0, code[6:0]} : code;
		for (int y = 0; y < GLYPH_ROWS; y++)
			if (!loaded[12'(g * GLYPH_STRIDE + y)])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic drain();
		while (accepted_cnt != queued_cnt || glyph_rows_due.size() != 0)
			@(posedge clk);
		repeat (GLYPH_ROWS + 8) @(posedge clk);
	endtask

	initial begin
		cfg_t c;
		int unsigned n;
		int unsigned pick;
		int unsigned rows;
		int unsigned tries;
		logic [7:0] code;
		cfg = '{1'b1, BLINK_PERIOD_RESET, CURSOR_START_RESET, CURSOR_END_RESET, 1'b0,
			CURSOR_ADDR_RESET};
		lit = 1'b0;
		countdown = BLINK_PERIOD_RESET;
		prev_cursor = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int y = 0; y < GLYPH_ROWS; y++)
			send_load(8'h00, 4'(y), FIRST_GLYPH[y]);
		send_load(8'hFF, 4'hF, 8'hFF);
		send_render(11'h7FF, 8'h00);
		send_render(11'h000, 8'h00);
		send_render(11'h7FF, 8'h00);
		drain();

		c = cfg;
		c.blink_enable = 1'b0;
		c.blink_period = 16'h0000;
		c.cursor_start_row = 5'd0;
		c.cursor_end_row = 5'd31;
		c.inverse_mode = 1'b1;
		c.cursor_address = 11'h000;
		set_config(c);
		send_render(11'h000, 8'h80);
		send_render(11'h005, 8'h80);
		send_render(11'h000, 8'h00);
		drain();

		c.blink_enable = 1'b1;
		c.cursor_start_row = 5'd5;
		c.cursor_end_row = 5'd2;
		set_config(c);
		send_render(11'h000, 8'h00);
		send_render(11'h000, 8'h80);
		drain();

		c.blink_period = 16'hFFFF;
		c.cursor_start_row = 5'd31;
		c.cursor_end_row = 5'd31;
		c.inverse_mode = 1'b0;
		set_config(c);
		send_render(11'h000, 8'h00);
		drain();

		for (int p = 0; p < 10; p++) begin
			c.blink_enable = (p % 4 != 3);
			case (p % 5)
				0: c.blink_period = 16'd0;
				1: c.blink_period = 16'd1;
				2: c.blink_period = 16'($urandom_range(2, 6));
				3: c.blink_period = 16'hFFFF;
				default: c.blink_period = 16'($urandom_range(0, 20));
			endcase
			c.cursor_start_row = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(0, GLYPH_ROWS));
			c.cursor_end_row = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(0, GLYPH_ROWS));
			c.inverse_mode = (p % 2 == 1);
			if (p == 2)
				c.cursor_address = 11'h000;
			else if (p == 5)
				c.cursor_address = 11'h7FF;
			else if (p != 7)
				c.cursor_address = 11'($urandom_range(0, 2047));
			set_config(c);
			sender_idles = (p % 3 != 1);
			receiver_stalls = (p % 3 != 2);
			n = 0;
			while (n < 40) begin
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					code = 8'($urandom_range(0, 255));
					rows = $urandom_range(0, 1) ? GLYPH_STRIDE : GLYPH_ROWS;
					for (int y = 0; y < rows; y++)
						send_load(code, 4'(y), 8'($urandom_range(0, 255)));
					n += rows;
				end else if (pick < 22) begin
					send_load(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
						8'($urandom_range(0, 255)));
					n++;
				end else begin
					tries = 0;
					code = 8'($urandom_range(0, 255));
					while (!glyph_ready(code) && tries < 64) begin
						code = 8'($urandom_range(0, 255));
						tries++;
					end
					if (!glyph_ready(code))
						code = (cfg.inverse_mode && $urandom_range(0, 1)) ? 8'h80 : 8'h00;
					send_render(pick < 60 ? c.cursor_address : 11'($urandom_range(0, 2047)),
						code);
					n++;
				end
			end
			drain();
		end

		$display("Sent %0d font writes and %0d cell renders, %0d of them on the cursor cell,",
			font_writes, cells_drawn, cursor_visits);
		$display("under %0d register settings; %0d glyph rows compared.", settings_used,
			rows_seen);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
